FILE: hw/rtl/lrp_pkg.sv
// Shared types, constants and helpers for the LIDAR axis range picker.
// No dependencies; every other file of the block refers to it by scoped names.
package lrp_pkg;

	localparam int unsigned AngleW = 16;
	localparam int unsigned RangeW = 16;
	localparam int unsigned DirW   = 3;
	localparam int unsigned NumAx  = 4;

	// Default depth of the queue between front and back.
	localparam int unsigned QueueDepth = 2;

	// Reset values of the configuration registers.
	localparam logic [RangeW-1:0] BranchThrReset = 16'd4000;
	localparam logic [RangeW-1:0] WallThrReset   = 16'd800;

	// Configuration register indexes.
	localparam logic CfgBranchThr = 1'b0;
	localparam logic CfgWallThr   = 1'b1;

	// Axis slots, also the order in which widest is scanned.
	localparam int unsigned AxF = 0;
	localparam int unsigned AxB = 1;
	localparam int unsigned AxL = 2;
	localparam int unsigned AxR = 3;

	// Direction / heading codes.
	localparam logic [DirW-1:0] DirNone = 3'd0;
	localparam logic [DirW-1:0] DirF    = 3'd1;
	localparam logic [DirW-1:0] DirB    = 3'd2;
	localparam logic [DirW-1:0] DirL    = 3'd3;
	localparam logic [DirW-1:0] DirR    = 3'd4;

	// Axis centers in centidegrees.
	localparam logic [AngleW-1:0] AngHalf  = 16'd18000;
	localparam logic [AngleW-1:0] AngFull  = 16'd36000;
	localparam logic [AngleW-1:0] AngLeft  = 16'd9000;
	localparam logic [AngleW-1:0] AngRight = 16'd27000;

	// One finished scan, handed from front to back.
	typedef struct packed {
		logic [NumAx-1:0][RangeW-1:0] rng;
		logic [DirW-1:0]              heading;
	} lrp_scan_t;

	// Push request from front into the queue.
	typedef struct packed {
		logic      push;
		lrp_scan_t scan;
	} lrp_push_t;

	function automatic logic [AngleW-1:0] abs_diff(input logic [AngleW-1:0] a,
			input logic [AngleW-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	// Angular distance of angle a from axis slot ax.
	function automatic logic [AngleW-1:0] axis_dist(input int unsigned ax,
			input logic [AngleW-1:0] a);
		logic [AngleW-1:0] d;
		unique case (ax)
			AxF:     d = (a >= AngHalf) ? abs_diff(a, AngFull) : a;
			AxB:     d = abs_diff(a, AngHalf);
			AxL:     d = abs_diff(a, AngLeft);
			default: d = abs_diff(a, AngRight);
		endcase
		axis_dist = d;
	endfunction

endpackage

FILE: hw/rtl/lrp_front.sv
// Front part: accepts scan points and keeps the nearest point for each axis.
// Depends on lrp_pkg; pushes each finished scan into lrp_queue.
module lrp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lrp_pkg::AngleW-1:0] angle_cdeg,
	input  logic [lrp_pkg::RangeW-1:0] range_mm,
	input  logic [lrp_pkg::DirW-1:0]   heading,
	input  logic                       scan_end,
	input  logic                       q_full,
	output lrp_pkg::lrp_push_t         q_push
);

	logic [lrp_pkg::NumAx-1:0][lrp_pkg::AngleW-1:0] best_dist_q;
	logic [lrp_pkg::NumAx-1:0][lrp_pkg::RangeW-1:0] best_rng_q;
	logic                                           have_q;

	logic [lrp_pkg::NumAx-1:0][lrp_pkg::AngleW-1:0] dist_new;
	logic [lrp_pkg::NumAx-1:0][lrp_pkg::AngleW-1:0] best_dist_nxt;
	logic [lrp_pkg::NumAx-1:0][lrp_pkg::RangeW-1:0] best_rng_nxt;
	logic                                           accept;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	// Replace an axis on the first point of a scan or when strictly closer.
	always_comb begin
		for (int unsigned i = 0; i < lrp_pkg::NumAx; i++) begin
			dist_new[i] = lrp_pkg::axis_dist(i, angle_cdeg);
			if (!have_q || (dist_new[i] < best_dist_q[i])) begin
				best_dist_nxt[i] = dist_new[i];
				best_rng_nxt[i]  = range_mm;
			end else begin
				best_dist_nxt[i] = best_dist_q[i];
				best_rng_nxt[i]  = best_rng_q[i];
			end
		end
	end

	always_comb begin
		q_push.push         = accept & scan_end;
		q_push.scan.rng     = best_rng_nxt;
		q_push.scan.heading = heading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (accept) begin
			have_q <= ~scan_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			best_dist_q <= best_dist_nxt;
			best_rng_q  <= best_rng_nxt;
		end
	end

endmodule

FILE: hw/rtl/lrp_queue.sv
// Short register queue of finished scans between front and back.
// Depends on lrp_pkg for the scan record and push struct.
module lrp_queue #(
	parameter int unsigned DEPTH = lrp_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lrp_pkg::lrp_push_t q_push,
	output logic               q_full,
	output logic               q_empty,
	input  logic               pop,
	output lrp_pkg::lrp_scan_t head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	lrp_pkg::lrp_scan_t slot_q [DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign q_full  = (count_q == CntW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_push = q_push.push & ~q_full;
	assign do_pop  = pop & ~q_empty;
	assign head    = slot_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : (p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_push.scan;
		end
	end

endmodule

FILE: hw/rtl/lrp_back.sv
// Back part: turns a finished scan into widest, branch and wall results.
// Depends on lrp_pkg; pulls from lrp_queue and holds one output register.
module lrp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  lrp_pkg::lrp_scan_t         head,
	output logic                       pop,
	input  logic [lrp_pkg::RangeW-1:0] branch_thr,
	input  logic [lrp_pkg::RangeW-1:0] wall_thr,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lrp_pkg::RangeW-1:0] fwd_range,
	output logic [lrp_pkg::RangeW-1:0] back_range,
	output logic [lrp_pkg::RangeW-1:0] left_range,
	output logic [lrp_pkg::RangeW-1:0] right_range,
	output logic [lrp_pkg::DirW-1:0]   widest_dir,
	output logic [lrp_pkg::RangeW-1:0] widest_range,
	output logic [lrp_pkg::DirW-1:0]   branch_dir,
	output logic [lrp_pkg::RangeW-1:0] branch_range,
	output logic                       wall_hit
);

	logic                       valid_q;
	logic [lrp_pkg::DirW-1:0]   wdir;
	logic [lrp_pkg::RangeW-1:0] wrng;
	logic [lrp_pkg::RangeW-1:0] c0, c1, cmax;
	logic [lrp_pkg::DirW-1:0]   d0, d1, cdir;
	logic [lrp_pkg::DirW-1:0]   bdir;
	logic [lrp_pkg::RangeW-1:0] brng;
	logic [lrp_pkg::RangeW-1:0] head_rng;
	logic                       head_ok;
	logic                       wall;

	assign out_valid = valid_q;
	assign pop       = ~q_empty & (~valid_q | ~out_stall);

	// Widest: scan f, b, l, r with strict greater-than.
	always_comb begin
		wdir = lrp_pkg::DirNone;
		wrng = '0;
		for (int unsigned i = 0; i < lrp_pkg::NumAx; i++) begin
			if (head.rng[i] > wrng) begin
				wrng = head.rng[i];
				wdir = lrp_pkg::DirW'(i + 1);
			end
		end
	end

	// Perpendicular candidates and heading range.
	always_comb begin
		c0       = '0;
		c1       = '0;
		d0       = lrp_pkg::DirNone;
		d1       = lrp_pkg::DirNone;
		head_ok  = 1'b1;
		head_rng = '0;
		unique case (head.heading)
			lrp_pkg::DirF, lrp_pkg::DirB: begin
				c0 = head.rng[lrp_pkg::AxL];
				d0 = lrp_pkg::DirL;
				c1 = head.rng[lrp_pkg::AxR];
				d1 = lrp_pkg::DirR;
			end
			lrp_pkg::DirL, lrp_pkg::DirR: begin
				c0 = head.rng[lrp_pkg::AxF];
				d0 = lrp_pkg::DirF;
				c1 = head.rng[lrp_pkg::AxB];
				d1 = lrp_pkg::DirB;
			end
			default: head_ok = 1'b0;
		endcase
		unique case (head.heading)
			lrp_pkg::DirF: head_rng = head.rng[lrp_pkg::AxF];
			lrp_pkg::DirB: head_rng = head.rng[lrp_pkg::AxB];
			lrp_pkg::DirL: head_rng = head.rng[lrp_pkg::AxL];
			lrp_pkg::DirR: head_rng = head.rng[lrp_pkg::AxR];
			default:       head_rng = '0;
		endcase
	end

	always_comb begin
		cmax = '0;
		cdir = lrp_pkg::DirNone;
		if (c0 > cmax) begin
			cmax = c0;
			cdir = d0;
		end
		if (c1 > cmax) begin
			cmax = c1;
			cdir = d1;
		end
		if (head_ok && (cdir != lrp_pkg::DirNone) && (cmax >= branch_thr)) begin
			bdir = cdir;
			brng = cmax;
		end else begin
			bdir = lrp_pkg::DirNone;
			brng = '0;
		end
		wall = head_ok & (head_rng <= wall_thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fwd_range    <= head.rng[lrp_pkg::AxF];
			back_range   <= head.rng[lrp_pkg::AxB];
			left_range   <= head.rng[lrp_pkg::AxL];
			right_range  <= head.rng[lrp_pkg::AxR];
			widest_dir   <= wdir;
			widest_range <= wrng;
			branch_dir   <= bdir;
			branch_range <= brng;
			wall_hit     <= wall;
		end
	end

endmodule

FILE: hw/rtl/lidar_axis_range_picker.sv
// Top level of the LIDAR axis range picker: config registers, front, queue, back.
// Depends on lrp_pkg, lrp_front, lrp_queue and lrp_back.
//
//   Channel   Direction  Handshake                 Moves
//   in        sink       in_valid / in_stall       one scan point per transfer
//   out       source     out_valid / out_stall     one scan summary per transfer
//   cfg       sink       cfg_we (no wait)          one threshold register write
//
// One point is taken every cycle while in_stall is low; in_stall rises only while
// the scan queue is full. A scan summary goes through the queue, then the output
// register, to out_valid. The output register and the queue (QUEUE_DEPTH entries)
// absorb out_stall; the input keeps flowing until QUEUE_DEPTH + 1 summaries wait.
// arst_n clears the axis tracking, the queue and the output valid; thresholds
// return to 4000 mm (branch) and 800 mm (wall).
module lidar_axis_range_picker #(
	parameter int unsigned QUEUE_DEPTH = lrp_pkg::QueueDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lrp_pkg::RangeW-1:0] cfg_data,
	// scan point input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lrp_pkg::AngleW-1:0] angle_cdeg,
	input  logic [lrp_pkg::RangeW-1:0] range_mm,
	input  logic [lrp_pkg::DirW-1:0]   heading,
	input  logic                       scan_end,
	// scan summary output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lrp_pkg::RangeW-1:0] fwd_range,
	output logic [lrp_pkg::RangeW-1:0] back_range,
	output logic [lrp_pkg::RangeW-1:0] left_range,
	output logic [lrp_pkg::RangeW-1:0] right_range,
	output logic [lrp_pkg::DirW-1:0]   widest_dir,
	output logic [lrp_pkg::RangeW-1:0] widest_range,
	output logic [lrp_pkg::DirW-1:0]   branch_dir,
	output logic [lrp_pkg::RangeW-1:0] branch_range,
	output logic                       wall_hit
);

	logic [lrp_pkg::RangeW-1:0] branch_thr_q;
	logic [lrp_pkg::RangeW-1:0] wall_thr_q;

	lrp_pkg::lrp_push_t q_push;
	lrp_pkg::lrp_scan_t q_head;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;

	// Threshold registers; the user must write them only while the block is idle (unchecked).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			branch_thr_q <= lrp_pkg::BranchThrReset;
			wall_thr_q   <= lrp_pkg::WallThrReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrp_pkg::CfgBranchThr: branch_thr_q <= cfg_data;
				lrp_pkg::CfgWallThr:   wall_thr_q   <= cfg_data;
				default:               branch_thr_q <= branch_thr_q;
			endcase
		end
	end

	// Front: track the nearest point per axis, push a snapshot at scan end.
	lrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.angle_cdeg (angle_cdeg),
		.range_mm   (range_mm),
		.heading    (heading),
		.scan_end   (scan_end),
		.q_full     (q_full),
		.q_push     (q_push)
	);

	// Queue: hold finished scans so front and back stall independently.
	lrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_full  (q_full),
		.q_empty (q_empty),
		.pop     (q_pop),
		.head    (q_head)
	);

	// Back: decide widest, branch and wall, and register the summary.
	lrp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.branch_thr   (branch_thr_q),
		.wall_thr     (wall_thr_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fwd_range    (fwd_range),
		.back_range   (back_range),
		.left_range   (left_range),
		.right_range  (right_range),
		.widest_dir   (widest_dir),
		.widest_range (widest_range),
		.branch_dir   (branch_dir),
		.branch_range (branch_range),
		.wall_hit     (wall_hit)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for lidar_axis_range_picker: a directed table, then random scans.
// Depends on lrp_pkg and the block's RTL; expected summaries come from an in-bench axis tracker.

module testbench;
	import lrp_pkg::*;

	// Cycles without any transfer before the run is declared hung.
	localparam int unsigned QuietLimit  = 2000;
	localparam int unsigned RandPoints  = 450;
	// Rewrite the thresholds after roughly this many random points.
	localparam int unsigned PhasePoints = 75;
	localparam int unsigned MaxReports  = 10;

	// Heading codes outside the defined set: no branch is looked for, no wall is flagged.
	localparam logic [DirW-1:0] HdSpare5 = 3'd5;
	localparam logic [DirW-1:0] HdSpare6 = 3'd6;
	localparam logic [DirW-1:0] HdSpare7 = 3'd7;

	// Direction code of each axis slot, in the order widest is scanned.
	localparam logic [DirW-1:0] AxisCode [NumAx] = '{DirF, DirB, DirL, DirR};

	typedef struct packed {
		logic [AngleW-1:0] angle;
		logic [RangeW-1:0] reach;
		logic [DirW-1:0]   heading;
		logic              last;
	} scan_pt_t;

	typedef struct packed {
		logic [RangeW-1:0] fwd_range;
		logic [RangeW-1:0] back_range;
		logic [RangeW-1:0] left_range;
		logic [RangeW-1:0] right_range;
		logic [DirW-1:0]   widest_dir;
		logic [RangeW-1:0] widest_range;
		logic [DirW-1:0]   branch_dir;
		logic [RangeW-1:0] branch_range;
		logic              wall_hit;
	} summary_t;

	typedef enum logic {RowPoint, RowReg} row_kind_e;

	// One line of the directed table: either a scan point or a threshold write.
	typedef struct packed {
		row_kind_e         kind;
		logic              typed;
		scan_pt_t          pt;
		summary_t          want;
		logic              reg_idx;
		logic [RangeW-1:0] reg_val;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [RangeW-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [AngleW-1:0] angle_cdeg;
	logic [RangeW-1:0] range_mm;
	logic [DirW-1:0]   heading;
	logic              scan_end;
	logic              out_valid;
	logic              out_stall;
	logic [RangeW-1:0] fwd_range;
	logic [RangeW-1:0] back_range;
	logic [RangeW-1:0] left_range;
	logic [RangeW-1:0] right_range;
	logic [DirW-1:0]   widest_dir;
	logic [RangeW-1:0] widest_range;
	logic [DirW-1:0]   branch_dir;
	logic [RangeW-1:0] branch_range;
	logic              wall_hit;

	// Axis tracker state, mirrored from what the block should hold.
	logic [AngleW-1:0] kept_angle [NumAx];
	logic [RangeW-1:0] kept_dist  [NumAx];
	bit                seeded;
	logic [RangeW-1:0] branch_thr;
	logic [RangeW-1:0] wall_thr;

	summary_t          summaries_due [$];
	plan_row_t         plan [$];
	int unsigned       mismatches;
	int unsigned       quiet_cycles;
	// While set, neither side idles nor stalls.
	bit                calm;

	lidar_axis_range_picker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.angle_cdeg   (angle_cdeg),
		.range_mm     (range_mm),
		.heading      (heading),
		.scan_end     (scan_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fwd_range    (fwd_range),
		.back_range   (back_range),
		.left_range   (left_range),
		.right_range  (right_range),
		.widest_dir   (widest_dir),
		.widest_range (widest_range),
		.branch_dir   (branch_dir),
		.branch_range (branch_range),
		.wall_hit     (wall_hit)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Angular offset of angle a from the center of axis slot ax. Forward is measured
	// against 36000 from the half turn up and against 0 below it; angles past a full
	// turn are taken as they are.
	function automatic int unsigned axis_off(input int unsigned ax, input logic [AngleW-1:0] a);
		int unsigned v;
		int unsigned c;
		v = 32'(a);
		case (ax)
			AxF:     c = (v >= 32'(AngHalf)) ? 32'(AngFull) : 32'd0;
			AxB:     c = 32'(AngHalf);
			AxL:     c = 32'(AngLeft);
			default: c = 32'(AngRight);
		endcase
		axis_off = (v >= c) ? v - c : c - v;
	endfunction

	// Fold one accepted point into the axis tracker; on the closing point of a scan,
	// build the summary and clear the tracker for the next scan.
	task automatic track_point(input scan_pt_t p, output bit closed, output summary_t s);
		logic [RangeW-1:0] c0;
		logic [RangeW-1:0] c1;
		logic [RangeW-1:0] top;
		logic [DirW-1:0]   d0;
		logic [DirW-1:0]   d1;
		logic [DirW-1:0]   pick;
		int unsigned       hax;
		bit                steer;
		// The first point of a scan seeds every axis; later ones must be strictly closer,
		// so on a tie the point kept first stays.
		for (int ax = 0; ax < NumAx; ax++)
			if (!seeded || axis_off(ax, p.angle) < axis_off(ax, kept_angle[ax])) begin
				kept_angle[ax] = p.angle;
				kept_dist[ax]  = p.reach;
			end
		seeded = 1'b1;
		closed = p.last;
		s = '0;
		if (p.last) begin
			s.fwd_range   = kept_dist[AxF];
			s.back_range  = kept_dist[AxB];
			s.left_range  = kept_dist[AxL];
			s.right_range = kept_dist[AxR];
			// Strict greater-than from zero: all-zero ranges leave no widest direction.
			for (int ax = 0; ax < NumAx; ax++)
				if (kept_dist[ax] > s.widest_range) begin
					s.widest_range = kept_dist[ax];
					s.widest_dir   = AxisCode[ax];
				end
			steer = 1'b1;
			c0 = '0;
			c1 = '0;
			d0 = DirNone;
			d1 = DirNone;
			hax = AxF;
			case (p.heading)
				DirF, DirB: begin
					c0 = kept_dist[AxL]; d0 = DirL;
					c1 = kept_dist[AxR]; d1 = DirR;
				end
				DirL, DirR: begin
					c0 = kept_dist[AxF]; d0 = DirF;
					c1 = kept_dist[AxB]; d1 = DirB;
				end
				default: steer = 1'b0;
			endcase
			for (int ax = 0; ax < NumAx; ax++)
				if (AxisCode[ax] == p.heading)
					hax = ax;
			// No heading, no branch and no wall. A zero perpendicular range never counts,
			// even against a zero threshold.
			if (steer) begin
				top  = '0;
				pick = DirNone;
				if (c0 > top) begin
					top  = c0;
					pick = d0;
				end
				if (c1 > top) begin
					top  = c1;
					pick = d1;
				end
				if (pick != DirNone && top >= branch_thr) begin
					s.branch_dir   = pick;
					s.branch_range = top;
				end
				s.wall_hit = (kept_dist[hax] <= wall_thr);
			end
			for (int ax = 0; ax < NumAx; ax++) begin
				kept_angle[ax] = '0;
				kept_dist[ax]  = '0;
			end
			seeded = 1'b0;
		end
	endtask

	function automatic plan_row_t point_row(input logic [AngleW-1:0] a,
			input logic [RangeW-1:0] r, input logic [DirW-1:0] h, input logic e);
		point_row      = '0;
		point_row.kind = RowPoint;
		point_row.pt   = scan_pt_t'{a, r, h, e};
	endfunction

	function automatic plan_row_t typed_row(input logic [AngleW-1:0] a,
			input logic [RangeW-1:0] r, input logic [DirW-1:0] h, input logic e,
			input summary_t want);
		typed_row       = point_row(a, r, h, e);
		typed_row.typed = 1'b1;
		typed_row.want  = want;
	endfunction

	function automatic plan_row_t reg_row(input logic idx, input logic [RangeW-1:0] val);
		reg_row         = '0;
		reg_row.kind    = RowReg;
		reg_row.reg_idx = idx;
		reg_row.reg_val = val;
	endfunction

	// Append one line to the directed table.
	function automatic void add_row(input plan_row_t row);
		plan = {plan, row};
	endfunction

	function automatic void check_field(input string name, input logic [RangeW-1:0] want,
			input logic [RangeW-1:0] got);
		if (got !== want) begin
			if (mismatches < MaxReports)
				$display("%0t ns %s: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one point, hold it through stalls, and book its summary when the
	// transfer is certain. Starts and returns just after a rising edge.
	task automatic send_point(input scan_pt_t p, input bit typed, input summary_t want);
		bit       closed;
		summary_t s;
		while (!calm && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		angle_cdeg <= p.angle;
		range_mm   <= p.reach;
		heading    <= p.heading;
		scan_end   <= p.last;
		// Sample stall mid-cycle, where nothing is moving.
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		track_point(p, closed, s);
		if (closed)
			summaries_due = {summaries_due, (typed ? want : s)};
		@(posedge clk);
	endtask

	// Drop valid and let every booked summary come out before touching a threshold.
	task automatic settle();
		in_valid <= 1'b0;
		while (summaries_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [RangeW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgBranchThr: branch_thr = val;
			CfgWallThr:   wall_thr   = val;
		endcase
		@(posedge clk);
	endtask

	// Receiver side: stall about a third of the time, never while calm.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 33);

	// Check each summary transfer against the oldest booked one and watch for a hang.
	always @(negedge clk) begin
		summary_t got;
		summary_t want;
		bit       moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall)
			moved = 1'b1;
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			got = summary_t'{fwd_range, back_range, left_range, right_range, widest_dir,
				widest_range, branch_dir, branch_range, wall_hit};
			if (summaries_due.size() == 0) begin
				if (mismatches < MaxReports)
					$display("%0t ns summary with none expected: %p", $time, got);
				mismatches++;
			end else begin
				want = summaries_due.pop_front();
				check_field("fwd_range",    want.fwd_range,    got.fwd_range);
				check_field("back_range",   want.back_range,   got.back_range);
				check_field("left_range",   want.left_range,   got.left_range);
				check_field("right_range",  want.right_range,  got.right_range);
				check_field("widest_dir",   RangeW'(want.widest_dir),
					RangeW'(got.widest_dir));
				check_field("widest_range", want.widest_range, got.widest_range);
				check_field("branch_dir",   RangeW'(want.branch_dir),
					RangeW'(got.branch_dir));
				check_field("branch_range", want.branch_range, got.branch_range);
				check_field("wall_hit",     RangeW'(want.wall_hit), RangeW'(got.wall_hit));
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("no transfer for %0d cycles, %0d summaries outstanding", QuietLimit,
				summaries_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned       sent;
		int unsigned       phase;
		int unsigned       len;
		int unsigned       sel;
		int                a;
		int                d;
		logic [RangeW-1:0] bval;
		logic [RangeW-1:0] wval;
		scan_pt_t          p;

		// Drive every input to a known value before the first edge.
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CfgBranchThr;
		cfg_data   = '0;
		in_valid   = 1'b0;
		angle_cdeg = '0;
		range_mm   = '0;
		heading    = DirNone;
		scan_end   = 1'b0;
		out_stall  = 1'b0;
		calm       = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		seeded       = 1'b0;
		branch_thr   = BranchThrReset;
		wall_thr     = WallThrReset;
		for (int ax = 0; ax < NumAx; ax++) begin
			kept_angle[ax] = '0;
			kept_dist[ax]  = '0;
		end

		// Directed table. Summaries are typed in only where they are obvious; the other
		// rows go through the tracker.
		// Fresh out of reset: a zero point with no heading gives an all-zero summary.
		add_row(typed_row(16'd0, 16'd0, DirNone, 1'b1, summary_t'{16'd0, 16'd0,
			16'd0, 16'd0, DirNone, 16'd0, DirNone, 16'd0, 1'b0}));
		// Lone point at the top of both fields seeds all axes; left wins the tie over right.
		add_row(typed_row(16'd35999, 16'hFFFF, DirF, 1'b1, summary_t'{16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, DirF, 16'hFFFF, DirL, 16'hFFFF, 1'b0}));
		// Headings outside the defined set: no branch, no wall.
		add_row(typed_row(16'd0, 16'd100, HdSpare7, 1'b1, summary_t'{16'd100,
			16'd100, 16'd100, 16'd100, DirF, 16'd100, DirNone, 16'd0, 1'b0}));
		add_row(point_row(16'd18000, 16'd900, HdSpare5, 1'b1));
		add_row(point_row(16'd27000, 16'd5, HdSpare6, 1'b1));
		// A full scan around the circle, heading left.
		add_row(point_row(16'd100, 16'd5000, DirNone, 1'b0));
		add_row(point_row(16'd9000, 16'd4000, DirNone, 1'b0));
		add_row(point_row(16'd18050, 16'd300, DirNone, 1'b0));
		add_row(point_row(16'd27000, 16'd6000, DirNone, 1'b0));
		add_row(point_row(16'd35950, 16'd1200, DirL, 1'b1));
		// Equal offsets on both sides of an axis keep the earlier point; an angle
		// beyond a full turn still wins forward.
		add_row(point_row(16'd17900, 16'd1000, DirNone, 1'b0));
		add_row(point_row(16'd18100, 16'd2000, DirNone, 1'b0));
		add_row(point_row(16'd40000, 16'd3000, DirB, 1'b1));
		// Wall exactly at the threshold, then one past it.
		add_row(typed_row(16'd4500, 16'd800, DirB, 1'b1, summary_t'{16'd800,
			16'd800, 16'd800, 16'd800, DirF, 16'd800, DirNone, 16'd0, 1'b1}));
		add_row(point_row(16'hFFFF, 16'd801, DirB, 1'b1));
		// Branch exactly at the threshold against a neighbor one short.
		add_row(point_row(16'd0, 16'd100, DirNone, 1'b0));
		add_row(point_row(16'd9000, 16'd4000, DirNone, 1'b0));
		add_row(point_row(16'd27000, 16'd3999, DirF, 1'b1));
		// Heading right with forward and back tied.
		add_row(point_row(16'd18000, 16'd7000, DirNone, 1'b0));
		add_row(point_row(16'd0, 16'd7000, DirR, 1'b1));
		// Both thresholds at zero: zero ranges give no branch, but a zero wall hits.
		add_row(reg_row(CfgBranchThr, 16'd0));
		add_row(reg_row(CfgWallThr, 16'd0));
		add_row(typed_row(16'd0, 16'd0, DirF, 1'b1, summary_t'{16'd0, 16'd0,
			16'd0, 16'd0, DirNone, 16'd0, DirNone, 16'd0, 1'b1}));
		add_row(point_row(16'd9000, 16'd1, DirL, 1'b1));
		// Both thresholds at full scale.
		add_row(reg_row(CfgBranchThr, 16'hFFFF));
		add_row(reg_row(CfgWallThr, 16'hFFFF));
		add_row(typed_row(16'd27000, 16'hFFFF, DirR, 1'b1, summary_t'{16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, DirF, 16'hFFFF, DirF, 16'hFFFF, 1'b1}));
		add_row(point_row(16'd100, 16'd65534, DirL, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == RowReg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_point(plan[i].pt, plan[i].typed, plan[i].want);
			end
		end

		// Random scans of mostly short length. Each phase gets its own thresholds,
		// written only once the block has drained.
		sent  = 0;
		phase = 0;
		while (sent < RandPoints) begin
			if (sent >= phase * PhasePoints) begin
				case (phase)
					0: begin
						bval = BranchThrReset;
						wval = WallThrReset;
					end
					1: begin
						bval = '0;
						wval = 16'hFFFF;
					end
					2: begin
						bval = 16'hFFFF;
						wval = '0;
					end
					default: begin
						bval = ($urandom_range(0, 1) != 0) ? RangeW'($urandom_range(0, 65535))
							: RangeW'($urandom_range(0, 8000));
						wval = RangeW'($urandom_range(0, 3000));
					end
				endcase
				settle();
				write_reg(CfgBranchThr, bval);
				write_reg(CfgWallThr, wval);
				phase++;
			end
			// Hold a long stretch with no idling on either side.
			calm <= (sent >= 150 && sent < 250);
			len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			for (int k = 0; k < len; k++) begin
				// Angles: anywhere on the circle, hugging an axis center, or past a full turn.
				sel = $urandom_range(0, 99);
				if (sel < 60)
					a = $urandom_range(0, 35999);
				else if (sel < 85)
					a = int'(AngLeft) * int'($urandom_range(0, 4))
						+ int'($urandom_range(0, 40)) - 20;
				else
					a = $urandom_range(36000, 65535);
				if (a < 0)
					a = 0;
				// Ranges: full scale, around either threshold, the extremes, or up to 2000 mm.
				sel = $urandom_range(0, 99);
				if (sel < 30)
					d = $urandom_range(0, 65535);
				else if (sel < 50)
					d = int'(branch_thr) + int'($urandom_range(0, 4)) - 2;
				else if (sel < 70)
					d = int'(wall_thr) + int'($urandom_range(0, 4)) - 2;
				else if (sel < 80)
					d = 0;
				else if (sel < 88)
					d = 65535;
				else
					d = $urandom_range(0, 2000);
				if (d < 0)
					d = 0;
				if (d > 65535)
					d = 65535;
				p.angle   = a[AngleW-1:0];
				p.reach   = d[RangeW-1:0];
				p.heading = ($urandom_range(0, 99) < 80) ? DirW'($urandom_range(DirF, DirR))
					: DirW'($urandom_range(0, 7));
				p.last    = (k == len - 1);
				send_point(p, 1'b0, '0);
			end
			sent += len;
		end

		// Drain, then give any stray summary a chance to show up.
		calm <= 1'b0;
		settle();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && summaries_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lrp_pkg.sv
hw/rtl/lrp_front.sv
hw/rtl/lrp_queue.sv
hw/rtl/lrp_back.sv
hw/rtl/lidar_axis_range_picker.sv
bench/testbench.sv
